// ===== hw/rtl/clint_pkg.sv =====
// Shared types and constants for the core-local timer and interrupt block.
// No dependencies; every other file depends on this package.
`default_nettype none

package clint_pkg;

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 64;
    localparam int IRQ_W   = 4;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    localparam logic [ADDR_W-1:0] CMP_BASE  = 16'h4000;
    localparam logic [ADDR_W-1:0] TIME_ADDR = 16'hbff8;

    // compare slot index base: CMP_BASE in units of 8 bytes
    localparam logic [ADDR_W-4:0] CMP_SLOT_BASE = 13'h0800;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic eval;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/clint_if.sv =====
// Request and response channel interfaces of the core-local timer block.
// Depends on clint_pkg for field widths.
`default_nettype none

interface clint_req_if;
    logic                          valid;
    logic                          ready;
    logic [clint_pkg::CMD_W-1:0]   command;
    logic [clint_pkg::ADDR_W-1:0]  address;
    logic [clint_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output command, output address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    output ready);
endinterface

interface clint_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [clint_pkg::DATA_W-1:0]  read_data;
    logic                          bus_error;
    logic [clint_pkg::IRQ_W-1:0]   software_irqs;
    logic [clint_pkg::IRQ_W-1:0]   timer_irqs;

    modport source (output valid, output read_data, output bus_error,
                    output software_irqs, output timer_irqs, input ready);
    modport sink   (input valid, input read_data, input bus_error,
                    input software_irqs, input timer_irqs, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clint_ctrl.sv =====
// Sequencing state machine: capture, execute and evaluate one request.
// Depends on clint_pkg for the command struct; drives clint_dp.
`default_nettype none

module clint_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output clint_pkg::t_ctrl_cmd  o_cmd
);
    import clint_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_vld || i_out_ready);
    assign w_accept    = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_EVAL;
            ST_EVAL: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_req = w_accept;
        o_cmd.exec     = (r_state == ST_EXEC);
        o_cmd.eval     = (r_state == ST_EVAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.eval) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clint_dp.sv =====
// Datapath: request capture, time counter, msip bits, compare store and
// response register. Depends on clint_pkg; sequenced by clint_ctrl.
`default_nettype none

module clint_dp #(
    parameter int HART_COUNT = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire clint_pkg::t_ctrl_cmd         i_cmd,
    input  wire logic [clint_pkg::CMD_W-1:0]  i_command,
    input  wire logic [clint_pkg::ADDR_W-1:0] i_address,
    input  wire logic [clint_pkg::DATA_W-1:0] i_write_data,
    output logic [clint_pkg::DATA_W-1:0]      o_read_data,
    output logic                              o_bus_error,
    output logic [clint_pkg::IRQ_W-1:0]       o_software_irqs,
    output logic [clint_pkg::IRQ_W-1:0]       o_timer_irqs
);
    import clint_pkg::*;

    localparam int HW    = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;
    localparam int LANES = (HART_COUNT < IRQ_W) ? HART_COUNT : IRQ_W;

    logic [CMD_W-1:0]  r_command;
    logic [ADDR_W-1:0] r_address;
    logic [DATA_W-1:0] r_wdata;

    logic [DATA_W-1:0] r_time;
    logic              r_msip [HART_COUNT];
    logic              r_cmp_vld [HART_COUNT];
    logic [DATA_W-1:0] r_cmp_mem [HART_COUNT];
    logic [DATA_W-1:0] r_cmp_q;
    logic [DATA_W-1:0] r_cmp_lane [LANES];

    logic [DATA_W-1:0] r_rdata_p;
    logic              r_rd_cmp;
    logic              r_rd_vld;
    logic              r_err;

    logic [DATA_W-1:0] r_out_rdata;
    logic              r_out_err;
    logic [IRQ_W-1:0]  r_out_sw;
    logic [IRQ_W-1:0]  r_out_tm;
    logic [IRQ_W-1:0]  n_out_sw;
    logic [IRQ_W-1:0]  n_out_tm;

    logic              w_acc;
    logic              w_wr;
    logic              w_msip_reg;
    logic              w_cmp_reg;
    logic              w_time_reg;
    logic [ADDR_W-5:0] w_hart_m;
    logic [ADDR_W-4:0] w_hart_c;
    logic              w_msip_ok;
    logic              w_cmp_ok;
    logic              w_err;
    logic [HW-1:0]     w_idx_m;
    logic [HW-1:0]     w_idx_c;

    assign w_acc      = (r_command == CMD_READ) || (r_command == CMD_WRITE);
    assign w_wr       = (r_command == CMD_WRITE);
    assign w_msip_reg = (r_address < CMP_BASE);
    assign w_cmp_reg  = !w_msip_reg && (r_address < TIME_ADDR);
    assign w_time_reg = (r_address == TIME_ADDR);
    assign w_hart_m   = r_address[ADDR_W-3:2];
    assign w_hart_c   = r_address[ADDR_W-1:3] - CMP_SLOT_BASE;
    assign w_idx_m    = w_hart_m[HW-1:0];
    assign w_idx_c    = w_hart_c[HW-1:0];

    assign w_msip_ok = w_acc && w_msip_reg && (r_address[1:0] == 2'b00)
                       && (w_hart_m < (ADDR_W-4)'(HART_COUNT));
    assign w_cmp_ok  = w_acc && w_cmp_reg && (r_address[2:0] == 3'b000)
                       && (w_hart_c < (ADDR_W-3)'(HART_COUNT));
    assign w_err     = w_acc && ((w_msip_reg && (r_address[1:0] != 2'b00))
                       || (w_cmp_reg && (r_address[2:0] != 3'b000))
                       || (w_time_reg && w_wr)
                       || (!w_msip_reg && !w_cmp_reg && !w_time_reg));

    // hold the captured request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_command <= i_command;
            r_address <= i_address;
            r_wdata   <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            for (int h = 0; h < HART_COUNT; h++) begin
                r_msip[h]    <= 1'b0;
                r_cmp_vld[h] <= 1'b0;
            end
        end else if (i_cmd.exec) begin
            if (r_command == CMD_TICK) begin
                r_time <= r_time + DATA_W'(1);
            end
            if (w_msip_ok && w_wr) begin
                r_msip[w_idx_m] <= r_wdata[0];
            end
            if (w_cmp_ok && w_wr) begin
                r_cmp_vld[w_idx_c] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < LANES; h++) begin
                r_cmp_lane[h] <= '0;
            end
        end else if (i_cmd.exec && w_cmp_ok && w_wr) begin
            for (int h = 0; h < LANES; h++) begin
                if (w_hart_c == (ADDR_W-3)'(h)) begin
                    r_cmp_lane[h] <= r_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_cmp_ok && w_wr) begin
                r_cmp_mem[w_idx_c] <= r_wdata;
            end
            r_cmp_q <= r_cmp_mem[w_idx_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_err    <= w_err;
            r_rd_cmp <= w_cmp_ok && !w_wr;
            r_rd_vld <= r_cmp_vld[w_idx_c];
            if (w_msip_ok && !w_wr) begin
                r_rdata_p <= {{(DATA_W-1){1'b0}}, r_msip[w_idx_m]};
            end else if (w_acc && w_time_reg && !w_wr) begin
                r_rdata_p <= r_time;
            end else begin
                r_rdata_p <= '0;
            end
        end
    end

    always_comb begin
        n_out_sw = '0;
        n_out_tm = '0;
        for (int h = 0; h < LANES; h++) begin
            n_out_sw[h] = r_msip[h];
            n_out_tm[h] = (r_time >= r_cmp_lane[h]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_rdata <= r_rd_cmp ? (r_rd_vld ? r_cmp_q : '0) : r_rdata_p;
            r_out_err   <= r_err;
            r_out_sw    <= n_out_sw;
            r_out_tm    <= n_out_tm;
        end
    end

    assign o_read_data     = r_out_rdata;
    assign o_bus_error     = r_out_err;
    assign o_software_irqs = r_out_sw;
    assign o_timer_irqs    = r_out_tm;

endmodule

`default_nettype wire

// ===== hw/rtl/core_local_timer_interruptor.sv =====
// Top level of the core-local timer and software interrupt block.
// Depends on clint_pkg, clint_if, clint_ctrl and clint_dp.
//
//   port     dir  handshake      content
//   i_req    in   valid/ready    command, address, write_data
//   o_rsp    out  valid/ready    read_data, bus_error, software_irqs, timer_irqs
//
// Each request passes through capture, execute (counter step, register
// write, compare store read port) and evaluate (per-hart time >= compare).
// The response stays registered until taken; the next request is accepted
// in the same cycle as the response is taken.
// Reset clears time, msip bits and compare values; no clearing pass.
`default_nettype none

module core_local_timer_interruptor #(
    parameter int HART_COUNT = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    clint_req_if.sink    i_req,
    clint_rsp_if.source  o_rsp
);
    import clint_pkg::*;

    t_ctrl_cmd w_cmd;

    clint_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    clint_dp #(
        .HART_COUNT (HART_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_command       (i_req.command),
        .i_address       (i_req.address),
        .i_write_data    (i_req.write_data),
        .o_read_data     (o_rsp.read_data),
        .o_bus_error     (o_rsp.bus_error),
        .o_software_irqs (o_rsp.software_irqs),
        .o_timer_irqs    (o_rsp.timer_irqs)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_cmd.exec)
        else $error("accepted request not executed");

    a_exec_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> w_cmd.eval)
        else $error("execute not followed by evaluate");

    a_eval_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.eval |=> o_rsp.valid)
        else $error("evaluate did not raise response");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec || w_cmd.eval) |-> !i_req.ready)
        else $error("request accepted while busy");

endmodule

`default_nettype wire

// ===== dv/tb_core_local_timer_interruptor.sv =====
`timescale 1ns / 1ps
// Testbench for core_local_timer_interruptor: directed and random requests against an
// in-bench model of time, msip and compare state, with random stalls on both channels.
// Depends on clint_pkg, clint_if and the block itself.

module tb_core_local_timer_interruptor;
    import clint_pkg::*;

    localparam int HARTS = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0] MSIP_BASE = 16'h0000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bus_error;
        logic [IRQ_W-1:0]  software_irqs;
        logic [IRQ_W-1:0]  timer_irqs;
    } t_bus_rsp;

    logic i_clk;
    logic i_rst_n;

    clint_req_if req_bus ();
    clint_rsp_if rsp_bus ();

    core_local_timer_interruptor #(.HART_COUNT(HARTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [DATA_W-1:0] model_time = '0;
    logic              model_msip [HARTS] = '{default: 1'b0};
    logic [DATA_W-1:0] model_cmp  [HARTS] = '{default: '0};

    t_bus_rsp awaited_rsps [$];
    int       fail_count  = 0;
    bit       idle_on     = 1'b1;
    int       hold_cycles = 0;
    int       cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_bus_rsp compute_bus_rsp(input logic [CMD_W-1:0] cmd,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [DATA_W-1:0] wdata);
        t_bus_rsp    rsp;
        logic        wr;
        int unsigned hart;
        rsp = '0;
        wr  = (cmd == CMD_WRITE);
        case (cmd)
            CMD_TICK: begin
                model_time = model_time + 1;
            end
            CMD_READ, CMD_WRITE: begin
                if (addr < CMP_BASE) begin
                    if (addr[1:0] != 2'b00) begin
                        rsp.bus_error = 1'b1;
                    end else begin
                        hart = 32'((addr - MSIP_BASE) >> 2);
                        if (hart < HARTS) begin
                            if (wr) model_msip[hart] = wdata[0];
                            else    rsp.read_data = {63'd0, model_msip[hart]};
                        end
                    end
                end else if (addr < TIME_ADDR) begin
                    if (addr[2:0] != 3'b000) begin
                        rsp.bus_error = 1'b1;
                    end else begin
                        hart = 32'((addr - CMP_BASE) >> 3);
                        if (hart < HARTS) begin
                            if (wr) model_cmp[hart] = wdata;
                            else    rsp.read_data = model_cmp[hart];
                        end
                    end
                end else if (addr == TIME_ADDR) begin
                    if (wr) rsp.bus_error = 1'b1;
                    else    rsp.read_data = model_time;
                end else begin
                    rsp.bus_error = 1'b1;
                end
            end
            default: ;
        endcase
        for (int h = 0; h < HARTS && h < IRQ_W; h++) begin
            rsp.software_irqs[h] = model_msip[h];
            rsp.timer_irqs[h]    = (model_time >= model_cmp[h]);
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && req_bus.valid && req_bus.ready)
            awaited_rsps.push_back(compute_bus_rsp(req_bus.command, req_bus.address,
                                                   req_bus.write_data));
    end

    always @(posedge i_clk) begin : rsp_check
        t_bus_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
                $error("response with nothing awaited");
                fail_count++;
            end else begin
                want = awaited_rsps.pop_front();
                if (rsp_bus.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, rsp_bus.read_data);
                    fail_count++;
                end
                if (rsp_bus.bus_error !== want.bus_error) begin
                    $error("bus_error: expected %b, got %b", want.bus_error, rsp_bus.bus_error);
                    fail_count++;
                end
                if (rsp_bus.software_irqs !== want.software_irqs) begin
                    $error("software_irqs: expected %b, got %b", want.software_irqs,
                           rsp_bus.software_irqs);
                    fail_count++;
                end
                if (rsp_bus.timer_irqs !== want.timer_irqs) begin
                    $error("timer_irqs: expected %b, got %b", want.timer_irqs,
                           rsp_bus.timer_irqs);
                    fail_count++;
                end
            end
        end
    end

    // receiver: holds off while hold_cycles counts down, else random stall bursts while idle_on
    initial begin : rsp_drive
        int stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] wdata);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.command    <= cmd;
        req_bus.address    <= addr;
        req_bus.write_data <= wdata;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    task automatic await_drain();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_rsps.size() != 0);
    endtask

    task automatic test_reset_values();
        issue_request(CMD_READ, TIME_ADDR, '1);
        issue_request(CMD_READ, MSIP_BASE, '1);
        issue_request(CMD_READ, CMP_BASE + 16'h18, '0);
    endtask

    task automatic test_directed_access();
        issue_request(CMD_WRITE, MSIP_BASE, 64'hffff_ffff_ffff_fffe);
        issue_request(CMD_WRITE, MSIP_BASE, 64'h1);
        issue_request(CMD_WRITE, MSIP_BASE + 16'h0c, '1);
        issue_request(CMD_WRITE, MSIP_BASE + 16'h10, 64'h1);
        issue_request(CMD_READ,  MSIP_BASE + 16'h10, '0);
        issue_request(CMD_WRITE, CMP_BASE, '1);
        issue_request(CMD_WRITE, CMP_BASE + 16'h08, 64'd2);
        issue_request(CMD_WRITE, CMP_BASE + 16'h28, '0);
        issue_request(CMD_READ,  CMP_BASE, '0);
        issue_request(CMD_TICK,  16'hffff, '1);
        issue_request(CMD_TICK,  16'h0000, '0);
        issue_request(CMD_READ,  TIME_ADDR, '0);
        issue_request(CMD_WRITE, TIME_ADDR, 64'h1234);
        issue_request(CMD_WRITE, MSIP_BASE + 16'h01, 64'h1);
        issue_request(CMD_READ,  16'h3ffe, '0);
        issue_request(CMD_READ,  16'h3ffc, '0);
        issue_request(CMD_READ,  CMP_BASE + 16'h04, '0);
        issue_request(CMD_READ,  16'hbff0, '0);
        issue_request(CMD_READ,  16'hbffc, '0);
        issue_request(CMD_WRITE, 16'hffff, '1);
        issue_request(CMD_SPARE, TIME_ADDR, '1);
        issue_request(CMD_WRITE, CMP_BASE, '0);
        issue_request(CMD_TICK,  16'h5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    task automatic test_random_traffic(input int count, input bit allow_idle);
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        int unsigned       pick;
        int unsigned       hart;
        for (int i = 0; i < count; i++) begin
            if (allow_idle && i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            addr  = ADDR_W'($urandom);
            wdata = {$urandom, $urandom};
            hart  = $urandom_range(0, HARTS + 1);
            pick  = $urandom_range(0, 99);
            if (pick < 30) begin
                cmd = CMD_TICK;
            end else if (pick < 34) begin
                cmd = CMD_SPARE;
            end else begin
                cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    addr = ADDR_W'(MSIP_BASE + 4 * hart);
                end else if (pick < 60) begin
                    addr = ADDR_W'(CMP_BASE + 8 * hart);
                    case ($urandom_range(0, 3))
                        0: wdata = model_time + $urandom_range(0, 16) - 4;
                        1: wdata = '1;
                        2: wdata = model_time + 1;
                        default: ;
                    endcase
                end else if (pick < 75) begin
                    addr = TIME_ADDR;
                end else if (pick < 80) begin
                    addr = ADDR_W'(MSIP_BASE + 4 * hart + $urandom_range(1, 3));
                end else if (pick < 85) begin
                    addr = ADDR_W'(CMP_BASE + 8 * hart + $urandom_range(1, 7));
                end
            end
            issue_request(cmd, addr, wdata);
        end
    endtask

    task automatic test_output_hold_off();
        idle_on     = 1'b0;
        hold_cycles = 80;
        repeat (12) issue_request(CMD_TICK, ADDR_W'($urandom), {$urandom, $urandom});
        issue_request(CMD_READ, TIME_ADDR, '0);
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        test_random_traffic(10, 1'b0);
        await_drain();
        issue_request(CMD_READ, TIME_ADDR, '0);
        issue_request(CMD_WRITE, CMP_BASE + 16'h10, model_time + 3);
        repeat (4) issue_request(CMD_TICK, '0, '0);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.command    <= CMD_TICK;
        req_bus.address    <= '0;
        req_bus.write_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_access();
        test_output_hold_off();
        test_drain_pause();
        test_random_traffic(1100, 1'b1);
        idle_on = 1'b0;
        test_random_traffic(300, 1'b0);

        await_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/clint_pkg.sv
hw/rtl/clint_if.sv
hw/rtl/clint_ctrl.sv
hw/rtl/clint_dp.sv
hw/rtl/core_local_timer_interruptor.sv
dv/tb_core_local_timer_interruptor.sv
